FILE: hdl/eqp_pkg.sv
// Shared types, constants and the microcode program of the three-band peaking equalizer.
package eqp_pkg;

  localparam int NUM_BANDS = 3;
  localparam int BAND_W    = 2;
  localparam int COEF_W    = 24;
  localparam int CFG_W     = 48;
  localparam int NUM_REGS  = 2 * NUM_BANDS;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 5;

  localparam logic [CFG_W-1:0] FF_RESET = 48'h4000_0000_0000;
  localparam logic [CFG_W-1:0] FB_RESET = 48'h0;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [BAND_W-1:0] band_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MAC,
    OP_WAIT,
    OP_WRITE,
    OP_OUT
  } op_e;

  typedef enum logic [1:0] {
    C_B0,
    C_A1,
    C_B2,
    C_A2
  } coef_e;

  typedef enum logic [2:0] {
    T_X,
    T_PX,
    T_OX,
    T_PY,
    T_OY
  } tap_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_WAIT_IN,
    J_GOTO,
    J_GOTO_OUT_FREE
  } jmp_e;

  typedef struct packed {
    op_e   op;
    band_t band;
    coef_e coef;
    tap_e  tap;
    logic  neg;
    logic  clr;
    jmp_e  jmp;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t cw(op_e op, band_t band, coef_e coef, tap_e tap,
                               logic neg, logic clr, jmp_e jmp);
    ctrl_t w;
    w.op     = op;
    w.band   = band;
    w.coef   = coef;
    w.tap    = tap;
    w.neg    = neg;
    w.clr    = clr;
    w.jmp    = jmp;
    w.target = '0;
    return w;
  endfunction

  // Per band: five products, a wait step for the last add, one round/saturate/update step.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      5'd0:  w = cw(OP_IDLE,  2'd0, C_B0, T_X,  1'b0, 1'b0, J_WAIT_IN);
      5'd1:  w = cw(OP_MAC,   2'd0, C_B0, T_X,  1'b0, 1'b1, J_NEXT);
      5'd2:  w = cw(OP_MAC,   2'd0, C_A1, T_PX, 1'b0, 1'b0, J_NEXT);
      5'd3:  w = cw(OP_MAC,   2'd0, C_B2, T_OX, 1'b0, 1'b0, J_NEXT);
      5'd4:  w = cw(OP_MAC,   2'd0, C_A1, T_PY, 1'b1, 1'b0, J_NEXT);
      5'd5:  w = cw(OP_MAC,   2'd0, C_A2, T_OY, 1'b1, 1'b0, J_NEXT);
      5'd6:  w = cw(OP_WAIT,  2'd0, C_B0, T_X,  1'b0, 1'b0, J_NEXT);
      5'd7:  w = cw(OP_WRITE, 2'd0, C_B0, T_X,  1'b0, 1'b0, J_NEXT);
      5'd8:  w = cw(OP_MAC,   2'd1, C_B0, T_X,  1'b0, 1'b1, J_NEXT);
      5'd9:  w = cw(OP_MAC,   2'd1, C_A1, T_PX, 1'b0, 1'b0, J_NEXT);
      5'd10: w = cw(OP_MAC,   2'd1, C_B2, T_OX, 1'b0, 1'b0, J_NEXT);
      5'd11: w = cw(OP_MAC,   2'd1, C_A1, T_PY, 1'b1, 1'b0, J_NEXT);
      5'd12: w = cw(OP_MAC,   2'd1, C_A2, T_OY, 1'b1, 1'b0, J_NEXT);
      5'd13: w = cw(OP_WAIT,  2'd1, C_B0, T_X,  1'b0, 1'b0, J_NEXT);
      5'd14: w = cw(OP_WRITE, 2'd1, C_B0, T_X,  1'b0, 1'b0, J_NEXT);
      5'd15: w = cw(OP_MAC,   2'd2, C_B0, T_X,  1'b0, 1'b1, J_NEXT);
      5'd16: w = cw(OP_MAC,   2'd2, C_A1, T_PX, 1'b0, 1'b0, J_NEXT);
      5'd17: w = cw(OP_MAC,   2'd2, C_B2, T_OX, 1'b0, 1'b0, J_NEXT);
      5'd18: w = cw(OP_MAC,   2'd2, C_A1, T_PY, 1'b1, 1'b0, J_NEXT);
      5'd19: w = cw(OP_MAC,   2'd2, C_A2, T_OY, 1'b1, 1'b0, J_NEXT);
      5'd20: w = cw(OP_WAIT,  2'd2, C_B0, T_X,  1'b0, 1'b0, J_NEXT);
      5'd21: w = cw(OP_WRITE, 2'd2, C_B0, T_X,  1'b0, 1'b0, J_NEXT);
      5'd22: w = cw(OP_OUT,   2'd0, C_B0, T_X,  1'b0, 1'b0, J_GOTO_OUT_FREE);
      default: w = cw(OP_WAIT, 2'd0, C_B0, T_X, 1'b0, 1'b0, J_GOTO);
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/eqp_in_if.sv
// Input sample channel: valid/ready handshake with one signed sample per beat.
interface eqp_in_if #(
  parameter int W = 24
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: hdl/eqp_out_if.sv
// Output sample channel: valid/ready handshake with one signed sample per beat.
interface eqp_out_if #(
  parameter int W = 24
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: hdl/eqp_seq.sv
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
module eqp_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_busy_i,
  output logic           in_ready_o,
  output eqp_pkg::ctrl_t ctrl_o
);
  import eqp_pkg::*;

  step_t step_q, step_d;
  ctrl_t ctrl;

  assign ctrl       = ucode(step_q);
  assign ctrl_o     = ctrl;
  assign in_ready_o = (ctrl.op == OP_IDLE);

  always_comb begin
    step_d = step_q;
    case (ctrl.jmp)
      J_NEXT: begin
        step_d = step_q + step_t'(1);
      end
      J_WAIT_IN: begin
        if (in_valid_i) step_d = step_q + step_t'(1);
      end
      J_GOTO: begin
        step_d = ctrl.target;
      end
      J_GOTO_OUT_FREE: begin
        // hold until the output register can take the sample
        if (!out_busy_i) step_d = ctrl.target;
      end
      default: begin
        step_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: hdl/eqp_dp.sv
// Datapath: coefficient registers, band history, shared multiplier-accumulator, output register.
module eqp_dp #(
  parameter int SW  = 24,
  parameter int CFB = 22
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  eqp_pkg::ctrl_t                    ctrl_i,
  input  logic                              in_fire_i,
  input  logic signed [SW-1:0]              sample_in_i,
  input  logic                              cfg_we_i,
  input  logic [eqp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [eqp_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [SW-1:0]              sample_out_o,
  output logic                              out_busy_o
);
  import eqp_pkg::*;

  localparam int PROD_W = SW + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(64'd1 << (CFB - 1));
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;

  logic [CFG_W-1:0]           cfg_q [NUM_REGS];
  logic signed [SW-1:0]       px_q [NUM_BANDS];
  logic signed [SW-1:0]       ox_q [NUM_BANDS];
  logic signed [SW-1:0]       py_q [NUM_BANDS];
  logic signed [SW-1:0]       oy_q [NUM_BANDS];
  logic signed [SW-1:0]       x_q;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [ACC_W-1:0]    prod_ext, addend, rnd, shq;
  logic                       mac_q, neg_q, clr_q;
  logic                       out_valid_q;
  logic signed [SW-1:0]       sample_out_q;
  logic [CFG_W-1:0]           ff, fb;
  logic signed [COEF_W-1:0]   coef;
  logic signed [SW-1:0]       tap, y;
  logic                       out_load;

  assign ff = cfg_q[{ctrl_i.band, 1'b0}];
  assign fb = cfg_q[{ctrl_i.band, 1'b1}];

  always_comb begin
    case (ctrl_i.coef)
      C_B0:    coef = $signed(ff[CFG_W-1:COEF_W]);
      C_B2:    coef = $signed(ff[COEF_W-1:0]);
      C_A1:    coef = $signed(fb[CFG_W-1:COEF_W]);
      C_A2:    coef = $signed(fb[COEF_W-1:0]);
      default: coef = '0;
    endcase
  end

  always_comb begin
    case (ctrl_i.tap)
      T_X:     tap = x_q;
      T_PX:    tap = px_q[ctrl_i.band];
      T_OX:    tap = ox_q[ctrl_i.band];
      T_PY:    tap = py_q[ctrl_i.band];
      T_OY:    tap = oy_q[ctrl_i.band];
      default: tap = '0;
    endcase
  end

  assign prod_d   = tap * coef;
  assign prod_ext = ACC_W'(prod_q);
  assign addend   = neg_q ? -prod_ext : prod_ext;
  assign acc_d    = (clr_q ? '0 : acc_q) + addend;

  // round half up, floor shift, then clamp to the sample range
  assign rnd = acc_q + RND_BIAS;
  assign shq = rnd >>> CFB;
  always_comb begin
    if (shq > SAT_HI) begin
      y = SAT_HI[SW-1:0];
    end else if (shq < SAT_LO) begin
      y = SAT_LO[SW-1:0];
    end else begin
      y = shq[SW-1:0];
    end
  end

  assign out_busy_o   = out_valid_q && !out_ready_i;
  assign out_load     = (ctrl_i.op == OP_OUT) && !out_busy_o;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= (i % 2 == 0) ? FF_RESET : FB_RESET;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (cfg_idx_i == CFG_IDX_W'(i)) cfg_q[i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BANDS; b++) begin
        px_q[b] <= '0;
        ox_q[b] <= '0;
        py_q[b] <= '0;
        oy_q[b] <= '0;
      end
    end else if (ctrl_i.op == OP_WRITE) begin
      // advance the band's history
      ox_q[ctrl_i.band] <= px_q[ctrl_i.band];
      px_q[ctrl_i.band] <= x_q;
      oy_q[ctrl_i.band] <= py_q[ctrl_i.band];
      py_q[ctrl_i.band] <= y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q       <= 1'b0;
      neg_q       <= 1'b0;
      clr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mac_q <= (ctrl_i.op == OP_MAC);
      neg_q <= ctrl_i.neg;
      clr_q <= ctrl_i.clr;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (mac_q) acc_q <= acc_d;
    if (in_fire_i) begin
      x_q <= sample_in_i;
    end else if (ctrl_i.op == OP_WRITE) begin
      x_q <= y;
    end
    if (out_load) sample_out_q <= x_q;
  end

endmodule

FILE: hdl/three_band_peaking_eq.sv
// Three cascaded peaking biquads (direct form I) on one shared multiplier-accumulator.
//
// Samples enter on in_i and leave on out_o, both valid/ready channels with one
// signed sample per beat. Coefficients are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; indexes 6 and 7 are ignored. The user must write them only while
// no sample is in flight; the block does not enforce this. A microcode program
// steps the datapath: per band five products through one multiplier, a wait step
// for the last add, and a step to round, saturate and update the band history;
// the single multiplier computes all 15 products. The last step loads the result
// into the output register, and no new sample is taken until the program is idle.
// The output register holds a finished sample while the receiver stalls, and
// the next sample is accepted and filtered meanwhile; its last step holds until
// the output register is free.
// Reset clears the band histories, sets every band to unity gain (b0 = 1.0,
// all other coefficients zero) and empties the output register.
module three_band_peaking_eq #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  eqp_in_if.sink                         in_i,
  eqp_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [eqp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eqp_pkg::CFG_W-1:0]      cfg_data_i
);
  import eqp_pkg::*;

  ctrl_t ctrl;
  logic  in_fire;
  logic  out_busy;

  assign in_fire = in_i.valid && in_i.ready;

  eqp_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_busy_i (out_busy),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  eqp_dp #(
    .SW  (SAMPLE_WIDTH),
    .CFB (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_fire_i    (in_fire),
    .sample_in_i  (in_i.sample_in),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .sample_out_o (out_o.sample_out),
    .out_busy_o   (out_busy)
  );

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("sequencer still idle after taking a sample");

  a_write_after_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.op == OP_WRITE |-> $past(ctrl.op) == OP_WAIT)
    else $error("band write-back not preceded by accumulate wait");

  a_out_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_OUT) && !out_busy |=> out_o.valid)
    else $error("output step did not raise valid");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> ctrl.op != OP_MAC && ctrl.op != OP_WRITE)
    else $error("ready raised while a sample is being filtered");
`endif

endmodule
